// File: design/swmg_pkg.sv
`default_nettype none
package swmg_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int RANGE_BITS  = 16;
	localparam int CFG_BITS    = 5;
	localparam int MAX_HALF_DEF = 16;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          waveform_last;
	} swmg_in_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_value;
		logic                  run_last;
		logic                  waveform_done;
	} swmg_out_t;

	// moves for the cell chain
	typedef struct packed {
		logic shift;
		logic step;
	} swmg_cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/swmg_cell.sv
`default_nettype none
module swmg_cell
	import swmg_pkg::*;
(
	input  wire  logic                          clk,
	input  wire  swmg_cell_ctrl_t               ctrl,
	input  wire  logic signed [SAMPLE_BITS-1:0] hist_in,
	input  wire  logic signed [SAMPLE_BITS-1:0] scan_in,
	output logic signed [SAMPLE_BITS-1:0]       hist_out,
	output logic signed [SAMPLE_BITS-1:0]       scan_out
);

	logic signed [SAMPLE_BITS-1:0] hist_q;
	logic signed [SAMPLE_BITS-1:0] scan_q;

	// history moves one cell older per word; the scan copy takes the shifted
	// history at once and then walks toward cell 0
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			hist_q <= hist_in;
			scan_q <= hist_in;
		end else if (ctrl.step) begin
			scan_q <= scan_in;
		end
	end

	assign hist_out = hist_q;
	assign scan_out = scan_q;

endmodule
`default_nettype wire

// File: design/swmg_ctrl.sv
`default_nettype none
module swmg_ctrl
	import swmg_pkg::*;
#(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          in_valid,
	output logic                                in_stall,
	input  wire  logic                          in_last,
	output logic                                out_valid,
	input  wire  logic                          out_stall,
	output swmg_out_t                           out_data,
	input  wire  logic                          cfg_we,
	input  wire  logic [CFG_BITS-1:0]           cfg_wdata,
	input  wire  logic signed [SAMPLE_BITS-1:0] scan_head,
	output swmg_cell_ctrl_t                     cell_ctrl
);

	localparam int DEPTH  = 2 * MAX_HALF + 1;
	localparam int HW     = $clog2(MAX_HALF + 1);
	localparam int SEEN_W = $clog2(DEPTH + 1);
	localparam int CW     = (HW > CFG_BITS) ? HW : CFG_BITS;
	localparam int DW     = (SAMPLE_BITS + 1 > RANGE_BITS) ? SAMPLE_BITS + 1 : RANGE_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [CFG_BITS-1:0]           half_q;
	logic [SEEN_W-1:0]             seen_q;
	logic [SEEN_W-1:0]             win_q;
	logic [SEEN_W-1:0]             cnt_q;
	logic [SEEN_W-1:0]             idx_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic [SEEN_W-1:0]             reps_q;
	logic                          fin_q;
	logic [RANGE_BITS-1:0]         val_q;

	logic                          accept;
	logic                          out_take;
	logic                          out_free;
	logic                          res_load;
	logic [HW-1:0]                 h_eff;
	logic [SEEN_W-1:0]             h_ext;
	logic [SEEN_W-1:0]             win_full;
	logic [SEEN_W-1:0]             seen_nx;
	logic [SEEN_W-1:0]             win_nx;
	logic [SEEN_W-1:0]             cnt_nx;
	logic signed [SAMPLE_BITS-1:0] lo_nx;
	logic signed [SAMPLE_BITS-1:0] hi_nx;
	logic signed [DW-1:0]          diff;

	// clamp the half width into 1..MAX_HALF
	always_comb begin
		if (half_q == '0)
			h_eff = HW'(1);
		else if (CW'(half_q) > CW'(MAX_HALF))
			h_eff = HW'(MAX_HALF);
		else
			h_eff = HW'(half_q);
	end

	assign h_ext    = SEEN_W'(h_eff);
	assign win_full = SEEN_W'({h_eff, 1'b1});
	assign seen_nx  = (seen_q == SEEN_W'(DEPTH)) ? seen_q : seen_q + SEEN_W'(1);
	assign win_nx   = (seen_nx < win_full) ? seen_nx : win_full;

	// number of result words this sample releases
	always_comb begin
		if (in_last)
			cnt_nx = (seen_nx > h_ext) ? h_ext + SEEN_W'(1) : seen_nx;
		else
			cnt_nx = (seen_nx > h_ext) ? SEEN_W'(1) : '0;
	end

	always_comb begin
		if (idx_q == '0) begin
			lo_nx = scan_head;
			hi_nx = scan_head;
		end else begin
			lo_nx = (scan_head < lo_q) ? scan_head : lo_q;
			hi_nx = (scan_head > hi_q) ? scan_head : hi_q;
		end
	end

	assign diff     = DW'(hi_q) - DW'(lo_q);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);
	assign out_valid = (reps_q != '0);
	assign out_take = out_valid && !out_stall;
	assign out_free = (reps_q == '0) || ((reps_q == SEEN_W'(1)) && out_take);
	assign res_load = (state_q == S_DONE) && (cnt_q != '0) && out_free;

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.step  = (state_q == S_SCAN);

	assign out_data.range_value   = val_q;
	assign out_data.run_last      = fin_q && (reps_q == SEEN_W'(1));
	assign out_data.waveform_done = fin_q && (reps_q == SEEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			half_q  <= CFG_BITS'(1);
			seen_q  <= '0;
			reps_q  <= '0;
		end else begin
			if (cfg_we)
				half_q <= cfg_wdata;
			if (res_load)
				reps_q <= cnt_q;
			else if (out_take)
				reps_q <= reps_q - SEEN_W'(1);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						seen_q  <= in_last ? '0 : seen_nx;
						win_q   <= win_nx;
						cnt_q   <= cnt_nx;
						last_q  <= in_last;
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					lo_q  <= lo_nx;
					hi_q  <= hi_nx;
					idx_q <= idx_q + SEEN_W'(1);
					if (idx_q == win_q - SEEN_W'(1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (cnt_q == '0) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						val_q   <= diff[RANGE_BITS-1:0];
						fin_q   <= last_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/sliding_window_morph_gradient_top.sv
`default_nettype none
// Range filter (max minus min) over a sliding window of 2h+1 signed samples.
// Input channel in_valid/in_stall carries one sample word with a last flag;
// output channel out_valid/out_stall carries range words with run_last and
// waveform_done set on the final word of a waveform. h is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. 0 acts as 1, above MAX_HALF as
// MAX_HALF. Results lag the input by h samples; the last sample releases
// h+1 equal words (fewer for waveforms of h samples or less). Each accepted
// sample is shifted into a chain of 2*MAX_HALF+1 cells and a copy of the
// chain walks past one min/max compare, one cell per cycle. With w = min(samples
// so far, 2h+1), S_SCAN takes w compare steps, then S_DONE loads the
// sample's result word, if any, once the output register is free; no new
// sample is taken until S_IDLE, so the compare walk sets the rate.
// The result sits in an output register, so a stalled receiver does not
// hold up the next scan; only a second result waiting on it does.
// Reset clears control state and sets h to 1; the cells need no clearing,
// since only samples of the current waveform are ever compared.
module sliding_window_morph_gradient_top
	import swmg_pkg::*;
#(
	parameter int MAX_HALF = MAX_HALF_DEF
) (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  logic                in_valid,
	output logic                      in_stall,
	input  wire  swmg_in_t            in_data,
	output logic                      out_valid,
	input  wire  logic                out_stall,
	output swmg_out_t                 out_data,
	input  wire  logic                cfg_we,
	input  wire  logic [CFG_BITS-1:0] cfg_wdata
);

	localparam int DEPTH = 2 * MAX_HALF + 1;

	swmg_cell_ctrl_t               cell_ctrl;
	logic signed [SAMPLE_BITS-1:0] hist [DEPTH];
	logic signed [SAMPLE_BITS-1:0] scan [DEPTH];

	genvar k;
	generate
		for (k = 0; k < DEPTH; k++) begin : g_cell
			logic signed [SAMPLE_BITS-1:0] hist_in;
			logic signed [SAMPLE_BITS-1:0] scan_in;
			if (k == 0) begin : g_head
				assign hist_in = in_data.sample;
			end else begin : g_body
				assign hist_in = hist[k-1];
			end
			if (k == DEPTH - 1) begin : g_tail
				assign scan_in = scan[k];
			end else begin : g_mid
				assign scan_in = scan[k+1];
			end
			swmg_cell u_cell (
				.clk      (clk),
				.ctrl     (cell_ctrl),
				.hist_in  (hist_in),
				.scan_in  (scan_in),
				.hist_out (hist[k]),
				.scan_out (scan[k])
			);
		end
	endgenerate

	swmg_ctrl #(
		.MAX_HALF (MAX_HALF)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_last   (in_data.waveform_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.scan_head (scan[0]),
		.cell_ctrl (cell_ctrl)
	);

endmodule
`default_nettype wire

// File: test/swmg_tb_pkg.sv
`timescale 1ns / 1ps
package swmg_tb_pkg;
	import swmg_pkg::*;

	localparam int HIST_DEPTH = 2 * MAX_HALF_DEF + 1;

	class range_scoreboard;
		logic signed [SAMPLE_BITS-1:0] recent_samples [HIST_DEPTH];
		int unsigned                   samples_in_wave;
		logic [CFG_BITS-1:0]           half_reg;
		swmg_out_t                     pending_ranges [$];
		int unsigned                   errors;

		function new();
			samples_in_wave = 0;
			half_reg = 1;
			errors = 0;
		endfunction

		function void set_half(logic [CFG_BITS-1:0] v);
			half_reg = v;
		endfunction

		// 0 behaves as 1, anything past MAX_HALF_DEF as the maximum
		function int unsigned eff_half();
			if (half_reg == 0)
				return 1;
			if (half_reg > MAX_HALF_DEF)
				return MAX_HALF_DEF;
			return half_reg;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		function void note_sample(swmg_in_t w);
			int unsigned h;
			int unsigned win;
			int unsigned n;
			logic signed [SAMPLE_BITS-1:0] lo;
			logic signed [SAMPLE_BITS-1:0] hi;
			logic [RANGE_BITS-1:0] span;
			swmg_out_t r;
			h = eff_half();
			for (int k = HIST_DEPTH - 1; k > 0; k--)
				recent_samples[k] = recent_samples[k-1];
			recent_samples[0] = w.sample;
			if (samples_in_wave < HIST_DEPTH)
				samples_in_wave++;
			win = 2 * h + 1;
			if (samples_in_wave < win)
				win = samples_in_wave;
			lo = recent_samples[0];
			hi = recent_samples[0];
			for (int k = 1; k < win; k++) begin
				if (recent_samples[k] < lo)
					lo = recent_samples[k];
				if (recent_samples[k] > hi)
					hi = recent_samples[k];
			end
			span = hi - lo;
			r.range_value = span;
			r.run_last = 1'b0;
			r.waveform_done = 1'b0;
			if (!w.waveform_last) begin
				if (samples_in_wave > h)
					pending_ranges.insert(pending_ranges.size(), r);
				return;
			end
			// last sample flushes h+1 copies, or one per sample if the wave is short
			n = (samples_in_wave > h) ? h + 1 : samples_in_wave;
			for (int k = 0; k < n; k++) begin
				r.run_last = (k + 1 == n);
				r.waveform_done = (k + 1 == n);
				pending_ranges.insert(pending_ranges.size(), r);
			end
			samples_in_wave = 0;
		endfunction

		task check_range_word(swmg_out_t got);
			swmg_out_t want;
			if (pending_ranges.size() == 0) begin
				report_mismatch($sformatf("unexpected word range=%0d", got.range_value));
				return;
			end
			want = pending_ranges.pop_front();
			if (got.range_value !== want.range_value)
				report_mismatch($sformatf("range_value got %0d want %0d",
					got.range_value, want.range_value));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last got %b want %b",
					got.run_last, want.run_last));
			if (got.waveform_done !== want.waveform_done)
				report_mismatch($sformatf("waveform_done got %b want %b",
					got.waveform_done, want.waveform_done));
		endtask
	endclass

endpackage

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
	import swmg_pkg::*;
	import swmg_tb_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int IDLE_PAUSE   = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_WORDS  = 45;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	swmg_in_t            in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	swmg_out_t           out_data;
	logic                cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;

	range_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int wave_left = 0;

	sliding_window_morph_gradient_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_range_word(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input bit last);
		swmg_in_t w;
		w.sample = s;
		w.waveform_last = last;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_sample(w);
	endtask

	task automatic write_half(input logic [CFG_BITS-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_half(v);
	endtask

	// drain everything, give a sample with no result time to finish its scan
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_ranges.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return 16'($urandom_range(0, 15)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_wave_len(int unsigned h);
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, h);
			2: return h + 1;
			3: return 2 * h + 1;
			default: return $urandom_range(h + 2, 3 * h + 4);
		endcase
	endfunction

	// waveforms run on across phase edges, so h also changes mid-waveform
	task automatic run_phase(input int words, input bit finish_wave);
		int sent;
		sent = 0;
		while (sent < words || (finish_wave && wave_left != 0)) begin
			if (wave_left == 0)
				wave_left = pick_wave_len(sb.eff_half());
			wave_left--;
			send_word(pick_sample(), wave_left == 0);
			sent++;
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] phase_half [NUM_PHASES];
		phase_half = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd0, 5'd5, 5'd9};
		phase_half[6] = 5'($urandom_range(0, 31));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// h acts as 1
		write_half(5'd0);
		send_word(16'sd5, 1'b1);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(-16'sd1, 1'b1);
		send_word(16'sd1, 1'b0);
		send_word(16'sd2, 1'b1);
		send_word(16'sd1000, 1'b0);
		send_word(-16'sd1000, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(16'sd0, 1'b0);
		send_word(16'sd5, 1'b1);
		drain_block();

		// h acts as the maximum; short waveform gives one word per sample
		write_half(5'd31);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sd7, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_block();
			write_half(phase_half[p]);
			if (p < 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 45;
			end else if (p < 6) begin
				send_idle_pct = 45;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 1 || p == 7)
				hold_req = 1'b1;
			run_phase(PHASE_WORDS, p == NUM_PHASES - 1);
		end

		drain_block();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sliding_window_morph_gradient_top.f
design/swmg_pkg.sv
design/swmg_cell.sv
design/swmg_ctrl.sv
design/sliding_window_morph_gradient_top.sv
test/swmg_tb_pkg.sv
test/tb.sv
